// ===== sv/cau_pkg.sv =====
// Shared types, codes and saturation helpers for the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;

  // Operation codes carried in the input tuser.
  localparam logic [2:0] KIND_ADD  = 3'd0;
  localparam logic [2:0] KIND_SUB  = 3'd1;
  localparam logic [2:0] KIND_MUL  = 3'd2;
  localparam logic [2:0] KIND_DIV  = 3'd3;
  localparam logic [2:0] KIND_CONJ = 3'd4;

  // Status codes carried in the output tuser.
  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_DZ  = 2'd1;
  localparam logic [1:0] STATUS_SAT = 2'd2;

  // Quotient bits produced by the divider, one per pipeline step.
  localparam int QBITS = 34;

  // One division lane: sign, early overflow, partial remainder and bits.
  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [63:0]      rem;
    logic [QBITS-1:0] nbits;
    logic [QBITS-1:0] quo;
  } cau_lane_t;

  // Item state as it travels down the divider pipeline.
  typedef struct packed {
    logic        is_div;
    logic        dz;
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  st;
    logic [63:0] den;
    cau_lane_t   lr;
    cau_lane_t   li;
  } cau_item_t;

  // Clamp a 33-bit signed value to 32 bits; the top bit flags saturation.
  function automatic logic [32:0] sat33(logic [32:0] x);
    logic [32:0] r;
    if (x[32] != x[31]) begin
      r = {1'b1, x[32] ? 32'h8000_0000 : 32'h7fff_ffff};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

  // Clamp a 65-bit signed value to 32 bits; the top bit flags saturation.
  function automatic logic [32:0] sat65(logic [64:0] x);
    logic [32:0] r;
    if ((&x[64:31]) || !(|x[64:31])) begin
      r = {1'b0, x[31:0]};
    end else begin
      r = {1'b1, x[64] ? 32'h8000_0000 : 32'h7fff_ffff};
    end
    return r;
  endfunction

  // Apply the sign to a quotient magnitude and clamp it to 32 bits.
  function automatic logic [32:0] pack_quo(cau_lane_t l);
    logic [32:0] r;
    if (l.ovf) begin
      r = {1'b1, l.neg ? 32'h8000_0000 : 32'h7fff_ffff};
    end else if (l.neg) begin
      if (l.quo > QBITS'(34'h0_8000_0000)) begin
        r = {1'b1, 32'h8000_0000};
      end else begin
        r = {1'b0, 32'(-l.quo)};
      end
    end else begin
      if (l.quo > QBITS'(34'h0_7fff_ffff)) begin
        r = {1'b1, 32'h7fff_ffff};
      end else begin
        r = {1'b0, l.quo[31:0]};
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/cau_front.sv =====
// Front pipeline: operand register, products, sums, rounding and divider set-up.
`timescale 1ns / 1ps
module cau_front import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_ar,
  input  logic [31:0] in_ai,
  input  logic [31:0] in_br,
  input  logic [31:0] in_bi,
  output logic        out_valid,
  output cau_item_t   out_item
);

  localparam int NW  = 64 + FRAC_BITS;
  localparam int SHR = QBITS - FRAC_BITS;

  // Stage 1: operand register.
  logic               v1_r;
  logic [2:0]         kind1_r;
  logic signed [31:0] ar1_r, ai1_r, br1_r, bi1_r;

  // Stage 2: products and the simple results before clamping.
  logic               v2_r;
  logic [2:0]         kind2_r;
  logic signed [63:0] prr2_r, pii2_r, pri2_r, pir2_r, qr2_r, qi2_r;
  logic signed [63:0] prr_nxt, pii_nxt, pri_nxt, pir_nxt, qr_nxt, qi_nxt;
  logic [32:0]        sre2_r, sim2_r, sre_nxt, sim_nxt;

  // Stage 3: exact sums and clamped simple results.
  logic               v3_r;
  logic [2:0]         kind3_r;
  logic [64:0]        mr3_r, mi3_r, dr3_r, di3_r;
  logic [63:0]        den3_r;
  logic [31:0]        sre3_r, sim3_r;
  logic [1:0]         sst3_r;
  logic [32:0]        csr, csi;

  // Stage 4: final value for all but divide, magnitudes for divide.
  logic               v4_r;
  logic               isdiv4_r, dz4_r, negr4_r, negi4_r;
  logic [31:0]        re4_r, im4_r;
  logic [1:0]         st4_r;
  logic [63:0]        magr4_r, magi4_r, den4_r;
  logic [31:0]        re_nxt, im_nxt;
  logic [1:0]         st_nxt;
  logic [64:0]        shr_r, shr_i;
  logic [32:0]        cmr, cmi;

  // Stage 5 set-up: scaled numerators, overflow check and first remainder.
  logic [NW-1:0]      nr_full, ni_full;
  logic [63:0]        hr, hi;
  cau_item_t          item_nxt, item_r;
  logic               v5_r;

  // Products are signed 32 by 32; the 64-bit target sets the width.
  assign prr_nxt = ar1_r * br1_r;
  assign pii_nxt = ai1_r * bi1_r;
  assign pri_nxt = ar1_r * bi1_r;
  assign pir_nxt = ai1_r * br1_r;
  assign qr_nxt  = br1_r * br1_r;
  assign qi_nxt  = bi1_r * bi1_r;

  // Add, subtract and conjugate in 33 bits so nothing wraps.
  always_comb begin
    sre_nxt = '0;
    sim_nxt = '0;
    case (kind1_r)
      KIND_ADD: begin
        sre_nxt = {ar1_r[31], ar1_r} + {br1_r[31], br1_r};
        sim_nxt = {ai1_r[31], ai1_r} + {bi1_r[31], bi1_r};
      end
      KIND_SUB: begin
        sre_nxt = {ar1_r[31], ar1_r} - {br1_r[31], br1_r};
        sim_nxt = {ai1_r[31], ai1_r} - {bi1_r[31], bi1_r};
      end
      KIND_CONJ: begin
        sre_nxt = {ar1_r[31], ar1_r};
        sim_nxt = 33'd0 - {ai1_r[31], ai1_r};
      end
      default: begin
        sre_nxt = '0;
        sim_nxt = '0;
      end
    endcase
  end

  assign csr = sat33(sre2_r);
  assign csi = sat33(sim2_r);

  // Product parts shift right with rounding toward minus infinity.
  assign shr_r = $signed(mr3_r) >>> FRAC_BITS;
  assign shr_i = $signed(mi3_r) >>> FRAC_BITS;
  assign cmr   = sat65(shr_r);
  assign cmi   = sat65(shr_i);

  always_comb begin
    re_nxt = sre3_r;
    im_nxt = sim3_r;
    st_nxt = sst3_r;
    if (kind3_r == KIND_MUL) begin
      re_nxt = cmr[31:0];
      im_nxt = cmi[31:0];
      st_nxt = (cmr[32] || cmi[32]) ? STATUS_SAT : STATUS_OK;
    end else if (kind3_r == KIND_DIV) begin
      re_nxt = '0;
      im_nxt = '0;
      st_nxt = (den3_r == '0) ? STATUS_DZ : STATUS_OK;
    end
  end

  // The quotient is formed from bit QBITS-1 down, so the bits above must be zero.
  assign nr_full = NW'(magr4_r) << FRAC_BITS;
  assign ni_full = NW'(magi4_r) << FRAC_BITS;
  assign hr      = magr4_r >> SHR;
  assign hi      = magi4_r >> SHR;

  always_comb begin
    item_nxt          = '0;
    item_nxt.is_div   = isdiv4_r;
    item_nxt.dz       = dz4_r;
    item_nxt.re       = re4_r;
    item_nxt.im       = im4_r;
    item_nxt.st       = st4_r;
    item_nxt.den      = den4_r;
    item_nxt.lr.neg   = negr4_r;
    item_nxt.lr.ovf   = hr >= den4_r;
    item_nxt.lr.rem   = hr;
    item_nxt.lr.nbits = nr_full[QBITS-1:0];
    item_nxt.li.neg   = negi4_r;
    item_nxt.li.ovf   = hi >= den4_r;
    item_nxt.li.rem   = hi;
    item_nxt.li.nbits = ni_full[QBITS-1:0];
  end

  // Valid bits of the five stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Payload registers of the five stages.
  always_ff @(posedge clk) begin
    if (en) begin
      kind1_r  <= in_kind;
      ar1_r    <= in_ar;
      ai1_r    <= in_ai;
      br1_r    <= in_br;
      bi1_r    <= in_bi;
      kind2_r  <= kind1_r;
      prr2_r   <= prr_nxt;
      pii2_r   <= pii_nxt;
      pri2_r   <= pri_nxt;
      pir2_r   <= pir_nxt;
      qr2_r    <= qr_nxt;
      qi2_r    <= qi_nxt;
      sre2_r   <= sre_nxt;
      sim2_r   <= sim_nxt;
      kind3_r  <= kind2_r;
      mr3_r    <= {prr2_r[63], prr2_r} - {pii2_r[63], pii2_r};
      mi3_r    <= {pri2_r[63], pri2_r} + {pir2_r[63], pir2_r};
      dr3_r    <= {prr2_r[63], prr2_r} + {pii2_r[63], pii2_r};
      di3_r    <= {pir2_r[63], pir2_r} - {pri2_r[63], pri2_r};
      den3_r   <= $unsigned(qr2_r) + $unsigned(qi2_r);
      sre3_r   <= csr[31:0];
      sim3_r   <= csi[31:0];
      sst3_r   <= (csr[32] || csi[32]) ? STATUS_SAT : STATUS_OK;
      isdiv4_r <= kind3_r == KIND_DIV;
      dz4_r    <= den3_r == '0;
      re4_r    <= re_nxt;
      im4_r    <= im_nxt;
      st4_r    <= st_nxt;
      negr4_r  <= dr3_r[64];
      negi4_r  <= di3_r[64];
      magr4_r  <= dr3_r[64] ? 64'(65'd0 - dr3_r) : dr3_r[63:0];
      magi4_r  <= di3_r[64] ? 64'(65'd0 - di3_r) : di3_r[63:0];
      den4_r   <= den3_r;
      item_r   <= item_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_item  = item_r;

endmodule

// ===== sv/cau_div_step.sv =====
// One restoring division step for both result lanes, with its pipeline register.
`timescale 1ns / 1ps
module cau_div_step import cau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  cau_item_t in_item,
  output logic      out_valid,
  output cau_item_t out_item
);

  logic      v_r;
  cau_item_t item_r, item_nxt;
  logic [64:0] tr, ti;
  logic        ger, gei;

  // Bring down the next numerator bit and try to subtract the divisor.
  assign tr  = {in_item.lr.rem, in_item.lr.nbits[QBITS-1]};
  assign ti  = {in_item.li.rem, in_item.li.nbits[QBITS-1]};
  assign ger = tr >= {1'b0, in_item.den};
  assign gei = ti >= {1'b0, in_item.den};

  always_comb begin
    item_nxt          = in_item;
    item_nxt.lr.rem   = ger ? 64'(tr - {1'b0, in_item.den}) : tr[63:0];
    item_nxt.lr.nbits = in_item.lr.nbits << 1;
    item_nxt.lr.quo   = {in_item.lr.quo[QBITS-2:0], ger};
    item_nxt.li.rem   = gei ? 64'(ti - {1'b0, in_item.den}) : ti[63:0];
    item_nxt.li.nbits = in_item.li.nbits << 1;
    item_nxt.li.quo   = {in_item.li.quo[QBITS-2:0], gei};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_item  = item_r;

endmodule

// ===== sv/complex_arithmetic_unit.sv =====
// Top level of the complex arithmetic unit: front stages, divider steps, output register.
//
//  Channel  Direction  Handshake          Payload
//  in_      slave      tvalid / tready    tdata: a_real, a_imag, b_real, b_imag; tuser: kind
//  out_     master     tvalid / tready    tdata: res_real, res_imag; tuser: status
//
// The pipeline has five front stages, one stage per quotient bit (34) and the output
// register. One item is accepted every cycle while the output side takes results.
// The whole pipeline advances together; a stall at the output holds every stage.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // a_real [31:0], a_imag [63:32], b_real [95:64], b_imag [127:96]
  input  logic [2:0]   in_tuser,  // kind [2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata, // res_real [31:0], res_imag [63:32]
  output logic [1:0]   out_tuser  // status [1:0]
);

  logic        en;
  logic        v_s   [QBITS+1];
  cau_item_t   it_s  [QBITS+1];
  logic        out_valid_r;
  logic [31:0] re_r, im_r, re_nxt, im_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [32:0] pr, pi;
  cau_item_t   last;

  // The pipeline moves whenever the output register is empty or being emptied.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser),
    .in_ar    (in_tdata[31:0]),
    .in_ai    (in_tdata[63:32]),
    .in_br    (in_tdata[95:64]),
    .in_bi    (in_tdata[127:96]),
    .out_valid(v_s[0]),
    .out_item (it_s[0])
  );

  // One step per quotient bit, most significant first.
  for (genvar g = 0; g < QBITS; g++) begin : g_div
    cau_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (v_s[g]),
      .in_item  (it_s[g]),
      .out_valid(v_s[g+1]),
      .out_item (it_s[g+1])
    );
  end

  // Final sign and clamp of the quotients.
  assign last = it_s[QBITS];
  assign pr   = pack_quo(last.lr);
  assign pi   = pack_quo(last.li);

  always_comb begin
    re_nxt = last.re;
    im_nxt = last.im;
    st_nxt = last.st;
    if (last.is_div && !last.dz) begin
      re_nxt = pr[31:0];
      im_nxt = pi[31:0];
      st_nxt = (pr[32] || pi[32]) ? STATUS_SAT : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_s[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {im_r, re_r};
  assign out_tuser  = st_r;

  // A waiting result must hold the input side off.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while the output was stalled");

  // Division by zero always delivers a zero result.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == STATUS_DZ) |-> (out_tdata == '0))
    else $error("division by zero gave a nonzero result");

  // The status code never takes the unused value.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == STATUS_OK || out_tuser == STATUS_DZ ||
                    out_tuser == STATUS_SAT))
    else $error("unused status code on the output");

  // A held result keeps its value until it is taken.
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_tvalid && !out_tready) |-> ($stable(out_tdata) && $stable(out_tuser)))
    else $error("a stalled result changed");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the complex arithmetic unit: directed, random and back-pressure tests.
`timescale 1ns / 1ps
module tb_top;
  import cau_pkg::*;

  localparam int FRAC       = 16;
  localparam int LATENCY    = 40;
  localparam int STALL_LIMIT = 5000;

  // One expected result item.
  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  st;
  } cplx_res_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // a_real, a_imag, b_real, b_imag
  logic [2:0]   in_tuser;   // kind
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;  // res_real, res_imag
  logic [1:0]   out_tuser;  // status

  cplx_res_t pending_results[$];
  int        err_count;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_off_cycles;
  int        quiet_cycles;

  complex_arithmetic_unit #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Clamp an exact value to 32 bits, flagging any saturation.
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout bit hit);
    if (v > 128'sh7fff_ffff) begin
      hit = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -128'sh8000_0000) begin
      hit = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Exact division of a numerator by a positive denominator, scaled and truncated to zero.
  function automatic logic signed [127:0] scaled_quotient(input logic signed [127:0] num,
                                                         input logic signed [127:0] den);
    logic signed [127:0] mag;
    logic signed [127:0] q;
    mag = (num < 0) ? -num : num;
    q   = (mag <<< FRAC) / den;
    return (num < 0) ? -q : q;
  endfunction

  // Compute the expected result of one operation.
  function automatic cplx_res_t complex_result(input logic [2:0] kind, input logic [31:0] a_re,
                                               input logic [31:0] a_im, input logic [31:0] b_re,
                                               input logic [31:0] b_im);
    cplx_res_t           r;
    bit                  hit;
    logic signed [127:0] ar, ai, br, bi, den;
    hit = 1'b0;
    ar  = $signed(a_re);
    ai  = $signed(a_im);
    br  = $signed(b_re);
    bi  = $signed(b_im);
    r.re = '0;
    r.im = '0;
    r.st = STATUS_OK;
    case (kind)
      KIND_ADD: begin
        r.re = clamp32(ar + br, hit);
        r.im = clamp32(ai + bi, hit);
      end
      KIND_SUB: begin
        r.re = clamp32(ar - br, hit);
        r.im = clamp32(ai - bi, hit);
      end
      KIND_MUL: begin
        r.re = clamp32((ar * br - ai * bi) >>> FRAC, hit);
        r.im = clamp32((ar * bi + ai * br) >>> FRAC, hit);
      end
      KIND_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.st = STATUS_DZ;
        end else begin
          r.re = clamp32(scaled_quotient(ar * br + ai * bi, den), hit);
          r.im = clamp32(scaled_quotient(ai * br - ar * bi, den), hit);
        end
      end
      KIND_CONJ: begin
        r.re = a_re;
        r.im = clamp32(-ai, hit);
      end
      default: begin
      end
    endcase
    if (hit) begin
      r.st = STATUS_SAT;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Idle for a random number of cycles, then offer one item and hold it until it is taken.
  task automatic send_item(input logic [2:0] kind, input logic [31:0] a_re,
                           input logic [31:0] a_im, input logic [31:0] b_re,
                           input logic [31:0] b_im);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {b_im, b_re, a_im, a_re};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(complex_result(kind, a_re, a_im, b_re, b_im));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Operand part biased towards extremes and small magnitudes.
  function automatic logic [31:0] random_part();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4: return 32'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] random_kind();
    if ($urandom_range(19) == 0) begin
      return 3'($urandom_range(5, 7));
    end
    return 3'($urandom_range(KIND_ADD, KIND_CONJ));
  endfunction

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    cplx_res_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        exp_res = pending_results.pop_front();
        if (out_tdata[31:0] !== exp_res.re)
          report_mismatch($sformatf("res_real %h, expected %h", out_tdata[31:0], exp_res.re));
        if (out_tdata[63:32] !== exp_res.im)
          report_mismatch($sformatf("res_imag %h, expected %h", out_tdata[63:32], exp_res.im));
        if (out_tuser !== exp_res.st)
          report_mismatch($sformatf("status %0d, expected %0d", out_tuser, exp_res.st));
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Extremes, every operation and the special cases.
  task automatic test_directed();
    send_item(KIND_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'hffff_ffff);
    send_item(KIND_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
    send_item(KIND_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hfffc_0000);
    send_item(KIND_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'hffff_ffff);
    send_item(KIND_SUB, 32'h0, 32'h0, 32'h8000_0000, 32'h7fff_ffff);
    send_item(KIND_MUL, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
    send_item(KIND_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(KIND_MUL, 32'hffff_ffff, 32'h0, 32'h1, 32'h0);
    send_item(KIND_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_item(KIND_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send_item(KIND_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
    send_item(KIND_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h1, 32'h0);
    send_item(KIND_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(KIND_DIV, 32'hffff_ffff, 32'h1, 32'h7fff_ffff, 32'h8000_0000);
    send_item(KIND_DIV, 32'h0, 32'h0, 32'h0, 32'h1);
    send_item(KIND_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    send_item(KIND_CONJ, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(3'd5, 32'h1234_5678, 32'h1, 32'h2, 32'h3);
    send_item(3'd6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(3'd7, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'h0);
    wait_drained();
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      send_item(random_kind(), random_part(), random_part(), random_part(), random_part());
    end
    wait_drained();
  endtask

  // Long receiver hold-off while items keep arriving, so the pipeline fills.
  task automatic test_backpressure();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 200;
    repeat (80) begin
      send_item(random_kind(), random_part(), random_part(), random_part(), random_part());
    end
    wait_drained();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = '0;
    err_count       = 0;
    quiet_cycles    = 0;
    hold_off_cycles = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(120, 0, 0);
    test_random(110, 79, 0);
    test_random(110, 0, 79);
    test_random(110, 20, 20);
    test_backpressure();

    repeat (LATENCY + 20) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
